[rtl/core/p4f_pkg.sv]
// ----------------------------------------------------------------------------
// p4f_pkg: shared types and constants of the polynomial fit block
// Field widths, coefficient register codes, queue item layout and the
// state encoding of the back end.
// ----------------------------------------------------------------------------
package p4f_pkg;

    localparam int X_W             = 16;
    localparam int Y_W             = 40;
    localparam int COEF_W          = 8;
    localparam int NUM_COEF        = 5;
    localparam int FRAC            = 12;
    localparam int ACC_W           = 36;
    localparam int DIFF_W          = Y_W + 1;
    localparam int HALF_W          = 19;
    localparam int SQ_LIMIT_BIT    = 2 * HALF_W;
    localparam int SQ_W            = 64;
    localparam int CFG_AW          = 3;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QLVL_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int DEF_MAX_SAMPLES = 256;
    localparam int IN_DATA_W       = 56;
    localparam int OUT_DATA_W      = Y_W + 2 * SQ_W;

    typedef enum logic [CFG_AW-1:0] {
        REG_COEFF_X4 = 3'd0,
        REG_COEFF_X3 = 3'd1,
        REG_COEFF_X2 = 3'd2,
        REG_COEFF_X1 = 3'd3,
        REG_COEFF_X0 = 3'd4
    } t_reg_idx;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef t_coef [NUM_COEF-1:0] t_coeffs;

    typedef struct packed {
        logic                  last;
        logic signed [Y_W-1:0] y;
        logic signed [X_W-1:0] x;
    } t_item;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QLVL_W-1:0] level;
    } t_q_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HORNER,
        ST_DIFF,
        ST_SQUARE,
        ST_SUMSQ,
        ST_ACCUM,
        ST_DIVIDE,
        ST_HOLD
    } t_state;

    function automatic logic signed [ACC_W-1:0] coef_q12(input t_coef c);
        coef_q12 = {{(ACC_W - COEF_W - FRAC){c[COEF_W-1]}}, c, {FRAC{1'b0}}};
    endfunction

endpackage

[rtl/core/poly4_fit_mse.sv]
// ----------------------------------------------------------------------------
// poly4_fit_mse: degree-4 polynomial fit with mean squared error
// Evaluates the configured polynomial per sample, gives the squared error and
// the mean squared error of a data set on its last sample.
//
// Channel   Dir  Handshake                    Beat contents
// s_axis    in   s_axis_tvalid/s_axis_tready  sample_x, measured_y, tlast
// m_axis    out  m_axis_tvalid/m_axis_tready  fitted_y, sq_error, mean, tuser
// cfg       in   i_cfg_valid/o_cfg_ready      register index, coefficient
//
// A sample passes from the queue to the output register in steps: one pop,
// four Horner steps on one 36x16 multiplier, then difference, square, sum,
// accumulate and output. The last sample of a set also passes through the
// bit-serial 64-bit divider. The input queue holds four samples, so input
// beats are taken while the back end works or the output stalls. Reset is
// synchronous and active low; coefficients reset to 1, sum and count to 0.
// ----------------------------------------------------------------------------
module poly4_fit_mse
    import p4f_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // sample_x [15:0], measured_y [55:16]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // fitted_y [39:0], sq_error [103:40], mean_sq_error [167:104]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // mean_valid [0]
    output logic                  m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_AW-1:0]     i_cfg_addr,
    input  logic [COEF_W-1:0]     i_cfg_data
);

    t_coeffs               r_coeffs;
    t_item                 w_in_item;
    t_item                 w_q_item;
    t_q_stat               w_q_stat;
    logic                  w_push;
    logic                  w_pop;
    logic signed [Y_W-1:0] w_fitted;
    logic [SQ_W-1:0]       w_sq;
    logic [SQ_W-1:0]       w_mean;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                r_coeffs[i] <= COEF_W'(1);
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                REG_COEFF_X4: r_coeffs[REG_COEFF_X4] <= i_cfg_data;
                REG_COEFF_X3: r_coeffs[REG_COEFF_X3] <= i_cfg_data;
                REG_COEFF_X2: r_coeffs[REG_COEFF_X2] <= i_cfg_data;
                REG_COEFF_X1: r_coeffs[REG_COEFF_X1] <= i_cfg_data;
                REG_COEFF_X0: r_coeffs[REG_COEFF_X0] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready  = !w_q_stat.full;
    assign w_push         = s_axis_tvalid && s_axis_tready;
    assign w_in_item.x    = s_axis_tdata[X_W-1:0];
    assign w_in_item.y    = s_axis_tdata[X_W+Y_W-1:X_W];
    assign w_in_item.last = s_axis_tlast;

    p4f_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_stat  (w_q_stat)
    );

    p4f_back #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_coeffs     (r_coeffs),
        .i_item_valid (!w_q_stat.empty),
        .i_item       (w_q_item),
        .o_pop        (w_pop),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_fitted     (w_fitted),
        .o_sq         (w_sq),
        .o_mean       (w_mean),
        .o_mean_valid (m_axis_tuser)
    );

    assign m_axis_tdata = {w_mean, w_sq, w_fitted};

    a_mean_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[OUT_DATA_W-1:Y_W+SQ_W] == '0)
        else $error("mean field not zero on a beat without mean_valid");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.level <= QLVL_W'(QUEUE_DEPTH))
        else $error("queue level above its depth");

    a_queue_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> w_q_stat.level == $past(w_q_stat.level) + 1'b1)
        else $error("queue level did not follow an input beat");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("back end took a sample from an empty queue");

endmodule

[rtl/core/p4f_queue.sv]
// ----------------------------------------------------------------------------
// p4f_queue: sample queue between input side and back end
// Short first-in first-out buffer of accepted samples.
// ----------------------------------------------------------------------------
module p4f_queue
    import p4f_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_item   o_item,
    output t_q_stat o_stat
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_item             r_mem [QUEUE_DEPTH];
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     r_rd;
    logic [QLVL_W-1:0] r_level;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        wrap_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (!i_push && i_pop) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rd];
    assign o_stat.empty = (r_level == '0);
    assign o_stat.full  = (r_level == QLVL_W'(QUEUE_DEPTH));
    assign o_stat.level = r_level;

endmodule

[rtl/core/p4f_div.sv]
// ----------------------------------------------------------------------------
// p4f_div: radix-2 restoring divider
// Unsigned quotient of a wide dividend by a narrow divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module p4f_div
    import p4f_pkg::*;
#(
    parameter int DW = SQ_W,
    parameter int VW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    r_quo;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [VW:0]      w_trial;
    logic             w_fits;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], w_fits};
            r_rem <= w_fits ? VW'(w_trial - {1'b0, r_div}) : w_trial[VW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/core/p4f_back.sv]
// ----------------------------------------------------------------------------
// p4f_back: polynomial evaluation, squared error and mean
// Sequencer that runs Horner steps on one shared multiplier, squares the
// error, keeps the running sum and count, and divides on the last sample.
// ----------------------------------------------------------------------------
module p4f_back
    import p4f_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_coeffs               i_coeffs,
    input  logic                  i_item_valid,
    input  t_item                 i_item,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [Y_W-1:0] o_fitted,
    output logic [SQ_W-1:0]       o_sq,
    output logic [SQ_W-1:0]       o_mean,
    output logic                  o_mean_valid
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    t_state                     r_state;
    t_state                     n_state;
    logic [1:0]                 r_step;
    logic signed [X_W-1:0]      r_x;
    logic signed [Y_W-1:0]      r_y;
    logic                       r_last;
    logic signed [ACC_W-1:0]    r_acc;
    logic [DIFF_W-1:0]          r_mag;
    logic                       r_big;
    logic [2*HALF_W-1:0]        r_hh;
    logic [2*HALF_W-1:0]        r_hl;
    logic [2*HALF_W-1:0]        r_ll;
    logic [SQ_W-1:0]            r_sq;
    logic [SQ_W-1:0]            r_sum;
    logic [CNT_W-1:0]           r_count;
    logic [SQ_W-1:0]            r_mean;
    logic                       r_out_valid;
    logic signed [Y_W-1:0]      r_out_fitted;
    logic [SQ_W-1:0]            r_out_sq;
    logic [SQ_W-1:0]            r_out_mean;
    logic                       r_out_mvalid;

    logic                       w_div_start;
    logic                       w_div_done;
    logic [SQ_W-1:0]            w_quotient;
    logic                       w_out_load;
    logic                       w_out_free;
    logic signed [ACC_W+X_W-1:0] w_prod;
    logic signed [ACC_W+X_W-1:0] w_prod_sh;
    logic [2:0]                 w_sel;
    logic signed [DIFF_W-1:0]   w_diff;
    logic [HALF_W-1:0]          w_hi;
    logic [HALF_W-1:0]          w_lo;
    logic [SQ_W:0]              w_sum_ext;
    logic [SQ_W-1:0]            w_sum_new;
    logic [CNT_W-1:0]           w_count_new;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_pop   = 1'b1;
                    n_state = ST_HORNER;
                end
            end
            ST_HORNER: begin
                if (r_step == 2'd3) begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF:   n_state = ST_SQUARE;
            ST_SQUARE: n_state = ST_SUMSQ;
            ST_SUMSQ:  n_state = ST_ACCUM;
            ST_ACCUM: begin
                if (r_last) begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIVIDE;
                end else begin
                    n_state = ST_HOLD;
                end
            end
            ST_DIVIDE: begin
                if (w_div_done) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign w_prod    = r_acc * r_x;
    assign w_prod_sh = w_prod >>> FRAC;
    assign w_sel     = 3'(r_step) + 3'd1;
    assign w_diff    = {r_y[Y_W-1], r_y} - {{(DIFF_W - ACC_W){r_acc[ACC_W-1]}}, r_acc};
    assign w_hi      = r_mag[2*HALF_W-1:HALF_W];
    assign w_lo      = r_mag[HALF_W-1:0];

    assign w_sum_ext   = {1'b0, r_sum} + {1'b0, r_sq};
    assign w_sum_new   = w_sum_ext[SQ_W] ? '1 : w_sum_ext[SQ_W-1:0];
    assign w_count_new = (r_count < CNT_W'(MAX_SAMPLES)) ? r_count + 1'b1 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_step <= '0;
                end
                ST_HORNER: begin
                    r_step <= r_step + 1'b1;
                end
                ST_ACCUM: begin
                    if (r_last) begin
                        r_sum   <= '0;
                        r_count <= '0;
                    end else begin
                        r_sum   <= w_sum_new;
                        r_count <= w_count_new;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x    <= i_item.x;
                r_y    <= i_item.y;
                r_last <= i_item.last;
                r_acc  <= coef_q12(i_coeffs[REG_COEFF_X4]);
            end
            ST_HORNER: begin
                r_acc <= w_prod_sh[ACC_W-1:0] + coef_q12(i_coeffs[w_sel]);
            end
            ST_DIFF: begin
                r_mag <= w_diff[DIFF_W-1] ? DIFF_W'(-w_diff) : DIFF_W'(w_diff);
            end
            ST_SQUARE: begin
                r_big <= |r_mag[DIFF_W-1:SQ_LIMIT_BIT];
                r_hh  <= w_hi * w_hi;
                r_hl  <= w_hi * w_lo;
                r_ll  <= w_lo * w_lo;
            end
            ST_SUMSQ: begin
                r_sq <= r_big ? '1 :
                        (SQ_W'(r_hh) << 26) + (SQ_W'(r_hl) << 8) + SQ_W'(r_ll >> FRAC);
            end
            ST_ACCUM: begin
                r_mean <= '0;
            end
            ST_DIVIDE: begin
                if (w_div_done) begin
                    r_mean <= w_quotient;
                end
            end
            default: ;
        endcase
    end

    p4f_div #(
        .DW (SQ_W),
        .VW (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_sum_new),
        .i_divisor  (w_count_new),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_fitted <= {{(Y_W - ACC_W){r_acc[ACC_W-1]}}, r_acc};
            r_out_sq     <= r_sq;
            r_out_mean   <= r_mean;
            r_out_mvalid <= r_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_fitted     = r_out_fitted;
    assign o_sq         = r_out_sq;
    assign o_mean       = r_out_mean;
    assign o_mean_valid = r_out_mvalid;

endmodule
